// File: hw/rtl/prt_pkg.sv
`default_nettype none

package prt_pkg;

  // Table geometry
  localparam int DEF_TABLE_DEPTH = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int EXP_CNT_W       = $clog2(MAX_RESULTS + 1);

  // Field widths
  localparam int ACTION_W = 3;
  localparam int CODE_W   = 32;
  localparam int CONN_W   = 16;
  localparam int TICK_W   = 32;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 3;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd30000;

  // Stream widths, rounded up to whole bytes
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 104;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT        = 3'd0,
    ACT_FIND          = 3'd1,
    ACT_REMOVE_SLOT   = 3'd2,
    ACT_REMOVE_CLIENT = 3'd3,
    ACT_REMOVE_SERVER = 3'd4,
    ACT_EXPIRE        = 3'd5,
    ACT_READ          = 3'd6
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_FULL         = 3'd1,
    ST_NOT_FOUND    = 3'd2,
    ST_EXPIRED      = 3'd3,
    ST_NONE_EXPIRED = 3'd4
  } status_t;

  // One table entry as it travels around the ring
  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
    logic [CONN_W-1:0] client;
    logic [CONN_W-1:0] server;
    logic [TICK_W-1:0] created;
  } entry_t;

  // Ring control from the sequencer: shift strobe and write-back entry
  typedef struct packed {
    logic   shift;
    entry_t wb;
  } ring_ctl_t;

  // Latched request
  typedef struct packed {
    action_t           action;
    logic [CODE_W-1:0] code;
    logic [CONN_W-1:0] client;
    logic [CONN_W-1:0] server;
    logic [TICK_W-1:0] now;
    logic [SLOT_W-1:0] slot;
    logic [CONN_W-1:0] conn;
  } req_t;

  // One result item
  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [CODE_W-1:0] code;
    logic [CONN_W-1:0] client;
    logic [CONN_W-1:0] server;
    logic [TICK_W-1:0] created;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/pending_request_table_core.sv
// Pending request table.
// Requests enter on the s_axis channel (tuser = action, tdata = fields) and
// results leave on the m_axis channel (tuser = status, tlast = final result
// of the request). The user must write the timeout register through
// cfg_we/cfg_data only while the block is idle; the block does not check.
// The table is a ring of TABLE_DEPTH entry cells. Each request rotates the
// ring once through the sequencer at its head, one entry per cycle while no
// expire result stalls it; the final result follows once the last entry has
// passed, and the next request is accepted only after that result is loaded
// into the output register. Action code 7 is accepted with no result and
// does not rotate the ring.
// Expire reports each expired entry in slot order, at most sixteen per
// request; its results leave while the ring keeps turning.
// A stalled receiver holds the output register; the ring halts only when a
// further expire result has nowhere to go, and the final result waits.
// Reset clears all valid marks, the sequencer and the output valid flag, and
// sets the timeout to 30000 ticks. Entry payloads are not reset.
`default_nettype none

module pending_request_table_core #(
  parameter int TABLE_DEPTH = prt_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // request: tdata = req_code, req_client, req_server, now_ticks,
  //          req_slot, conn_match, zero pad (low bit first)
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [prt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser = action
  input  wire logic [prt_pkg::ACTION_W-1:0]    s_axis_tuser,
  // result: tdata = out_slot, out_code, out_client, out_server,
  //         out_created, zero pad (low bit first)
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [prt_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // tuser = out_status
  output logic [prt_pkg::STATUS_W-1:0]         m_axis_tuser,
  // tlast = last_result
  output logic                                 m_axis_tlast,
  input  wire logic                            cfg_we,
  input  wire logic [prt_pkg::TICK_W-1:0]      cfg_data
);

  logic [prt_pkg::TICK_W-1:0] timeout_ticks;
  prt_pkg::req_t              in_req;
  prt_pkg::ring_ctl_t         ctl;
  prt_pkg::res_t              out_res;
  prt_pkg::entry_t            ring_q [TABLE_DEPTH];

  // Timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= prt_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ticks <= cfg_data;
    end
  end

  // Unpack the request
  always_comb begin
    in_req.action = prt_pkg::action_t'(s_axis_tuser);
    in_req.code   = s_axis_tdata[31:0];
    in_req.client = s_axis_tdata[47:32];
    in_req.server = s_axis_tdata[63:48];
    in_req.now    = s_axis_tdata[95:64];
    in_req.slot   = s_axis_tdata[99:96];
    in_req.conn   = s_axis_tdata[115:100];
  end

  // Ring of entry cells; the head writes back into the tail
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    prt_pkg::entry_t cell_d;
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign cell_d = ctl.wb;
    end else begin : g_body
      assign cell_d = ring_q[i+1];
    end
    prt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (ctl.shift),
      .d     (cell_d),
      .q     (ring_q[i])
    );
  end

  prt_seq #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_req        (in_req),
    .timeout_ticks (timeout_ticks),
    .head          (ring_q[0]),
    .ctl           (ctl),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_res       (out_res)
  );

  // Pack the result
  assign m_axis_tdata = {4'b0000, out_res.created, out_res.server, out_res.client,
                         out_res.code, out_res.slot};
  assign m_axis_tuser = out_res.status;
  assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire

// File: hw/rtl/prt_cell.sv
`default_nettype none

// One table entry of the ring; loads the entry on its d input on every shift.
module prt_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            shift,
  input  wire prt_pkg::entry_t d,
  output prt_pkg::entry_t      q
);

  prt_pkg::entry_t entry;

  // Valid mark clears at reset; payload holds until the next shift
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (shift) begin
      entry.valid <= d.valid;
    end
    if (shift) begin
      entry.code    <= d.code;
      entry.client  <= d.client;
      entry.server  <= d.server;
      entry.created <= d.created;
    end
  end

  assign q = entry;

endmodule

`default_nettype wire

// File: hw/rtl/prt_seq.sv
`default_nettype none

// Request sequencer: rotates the ring once per known action, inspects the
// head entry, writes it back as the action needs and forms the results.
module prt_seq #(
  parameter int TABLE_DEPTH = prt_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire prt_pkg::req_t                  in_req,
  input  wire logic [prt_pkg::TICK_W-1:0]     timeout_ticks,
  input  wire prt_pkg::entry_t                head,
  output prt_pkg::ring_ctl_t                  ctl,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output prt_pkg::res_t                       out_res
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CMP_W = (IDX_W > prt_pkg::SLOT_W) ? IDX_W : prt_pkg::SLOT_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t                           state;
  prt_pkg::req_t                    req;
  logic [IDX_W-1:0]                 cnt;
  logic                             done;
  logic [prt_pkg::EXP_CNT_W-1:0]    exp_cnt;
  logic [prt_pkg::SLOT_W-1:0]       res_slot;
  logic [prt_pkg::CODE_W-1:0]       res_code;
  logic [prt_pkg::CONN_W-1:0]       res_client;
  logic [prt_pkg::CONN_W-1:0]       res_server;
  logic [prt_pkg::TICK_W-1:0]       res_created;

  logic                             slot_hit;
  logic [prt_pkg::TICK_W-1:0]       age;
  logic                             expired;
  logic                             take;
  logic                             is_expire;
  logic                             out_free;
  logic                             stall;
  logic                             push_hold;
  prt_pkg::entry_t                  wb;
  prt_pkg::res_t                    hold_res;
  prt_pkg::res_t                    final_res;

  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign is_expire = (req.action == prt_pkg::ACT_EXPIRE);

  // Compare the head entry with the request
  assign slot_hit = (CMP_W'(cnt) == CMP_W'(req.slot));
  assign age      = req.now - head.created;
  assign expired  = head.valid && (age > timeout_ticks) &&
                    (exp_cnt < prt_pkg::EXP_CNT_W'(prt_pkg::MAX_RESULTS));

  // Decide the write-back entry for the head
  always_comb begin
    wb   = head;
    take = 1'b0;
    case (req.action)
      prt_pkg::ACT_INSERT: begin
        if (!head.valid && !done) begin
          wb.valid   = 1'b1;
          wb.code    = req.code;
          wb.client  = req.client;
          wb.server  = req.server;
          wb.created = req.now;
          take       = 1'b1;
        end
      end
      prt_pkg::ACT_FIND: begin
        take = head.valid && (head.code == req.code) && !done;
      end
      prt_pkg::ACT_REMOVE_SLOT: begin
        if (slot_hit && head.valid) begin
          wb.valid = 1'b0;
          take     = 1'b1;
        end
      end
      prt_pkg::ACT_REMOVE_CLIENT: begin
        if (head.valid && (head.client == req.conn)) begin
          wb.valid = 1'b0;
          take     = 1'b1;
        end
      end
      prt_pkg::ACT_REMOVE_SERVER: begin
        if (head.valid && (head.server == req.conn)) begin
          wb.valid = 1'b0;
          take     = 1'b1;
        end
      end
      prt_pkg::ACT_EXPIRE: begin
        if (expired) begin
          wb.valid = 1'b0;
          take     = 1'b1;
        end
      end
      prt_pkg::ACT_READ: begin
        take = slot_hit && head.valid;
      end
      default: begin
        take = 1'b0;
      end
    endcase
  end

  // A second expired entry pushes the held one out; stall if the output is busy
  assign stall     = is_expire && take && done && !out_free;
  assign push_hold = (state == S_SCAN) && is_expire && take && done && out_free;

  assign ctl = '{shift: (state == S_SCAN) && !stall, wb: wb};

  // Held expire result, not yet known to be the last
  always_comb begin
    hold_res         = '0;
    hold_res.status  = prt_pkg::ST_EXPIRED;
    hold_res.slot    = res_slot;
    hold_res.code    = res_code;
    hold_res.client  = res_client;
    hold_res.last    = 1'b0;
  end

  // Closing result of the request
  always_comb begin
    final_res      = '0;
    final_res.last = 1'b1;
    case (req.action) inside
      prt_pkg::ACT_INSERT: begin
        final_res.status = done ? prt_pkg::ST_OK : prt_pkg::ST_FULL;
        final_res.slot   = done ? res_slot : '0;
      end
      prt_pkg::ACT_FIND: begin
        final_res.status = done ? prt_pkg::ST_OK : prt_pkg::ST_NOT_FOUND;
        final_res.slot   = done ? res_slot : '0;
      end
      prt_pkg::ACT_REMOVE_SLOT: begin
        final_res.status = done ? prt_pkg::ST_OK : prt_pkg::ST_NOT_FOUND;
        final_res.slot   = req.slot;
      end
      prt_pkg::ACT_REMOVE_CLIENT, prt_pkg::ACT_REMOVE_SERVER: begin
        final_res.status = done ? prt_pkg::ST_OK : prt_pkg::ST_NOT_FOUND;
      end
      prt_pkg::ACT_EXPIRE: begin
        if (done) begin
          final_res.status = prt_pkg::ST_EXPIRED;
          final_res.slot   = res_slot;
          final_res.code   = res_code;
          final_res.client = res_client;
        end else begin
          final_res.status = prt_pkg::ST_NONE_EXPIRED;
        end
      end
      prt_pkg::ACT_READ: begin
        if (done) begin
          final_res.status  = prt_pkg::ST_OK;
          final_res.code    = res_code;
          final_res.client  = res_client;
          final_res.server  = res_server;
          final_res.created = res_created;
        end else begin
          final_res.status  = prt_pkg::ST_NOT_FOUND;
        end
        final_res.slot = req.slot;
      end
      default: begin
        final_res.status = prt_pkg::ST_OK;
      end
    endcase
  end

  // State, scan counters and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      done      <= 1'b0;
      exp_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req     <= in_req;
            cnt     <= '0;
            done    <= 1'b0;
            exp_cnt <= '0;
            case (in_req.action) inside
              prt_pkg::ACT_INSERT, prt_pkg::ACT_FIND, prt_pkg::ACT_REMOVE_SLOT,
              prt_pkg::ACT_REMOVE_CLIENT, prt_pkg::ACT_REMOVE_SERVER,
              prt_pkg::ACT_EXPIRE, prt_pkg::ACT_READ: state <= S_SCAN;
              default:                                state <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          if (ctl.shift) begin
            cnt <= (cnt == IDX_LAST) ? '0 : cnt + 1'b1;
            if (take) begin
              done        <= 1'b1;
              res_slot    <= prt_pkg::SLOT_W'(cnt);
              res_code    <= head.code;
              res_client  <= head.client;
              res_server  <= head.server;
              res_created <= head.created;
              if (is_expire) begin
                exp_cnt <= exp_cnt + 1'b1;
              end
            end
            if (cnt == IDX_LAST) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Load the output register, or drop it once taken
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
        out_res   <= final_res;
      end else if (push_hold) begin
        out_valid <= 1'b1;
        out_res   <= hold_res;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Only expire results may be non-final
  a_last_only_expire: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_res.status != prt_pkg::ST_EXPIRED) |-> out_res.last)
    else $error("non-final result outside expire");

  // Ring moves only while scanning
  a_shift_scan: assert property (@(posedge clk) disable iff (rst)
    ctl.shift |-> state == S_SCAN)
    else $error("ring shifted outside a scan");

  // Expire count stays within the result limit
  a_exp_limit: assert property (@(posedge clk) disable iff (rst)
    exp_cnt <= prt_pkg::EXP_CNT_W'(prt_pkg::MAX_RESULTS))
    else $error("too many expired entries");

  // Closing a request always presents a result
  a_done_emits: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_free |=> out_valid && out_res.last)
    else $error("closing result missing");

  // Scan index stays inside the table
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= IDX_LAST)
    else $error("scan index out of range");

endmodule

`default_nettype wire

// File: bench/pending_request_table_core_tb.sv
`timescale 1ns / 1ps

module pending_request_table_core_tb;

  localparam int TBL_DEPTH = prt_pkg::DEF_TABLE_DEPTH;
  localparam logic [prt_pkg::ACTION_W-1:0] ACT_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = TBL_DEPTH + 4;
  localparam int PHASE_COUNT = 6;
  localparam int PHASE_REQUESTS = 38;

  typedef struct {
    prt_pkg::req_t    req;
    int unsigned      reps;
    bit               typed;
    prt_pkg::status_t st;
    logic [3:0]       slot;
  } directed_row_t;

  logic                           clk;
  logic                           rst;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [prt_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic [prt_pkg::ACTION_W-1:0]   s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [prt_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [prt_pkg::STATUS_W-1:0]   m_axis_tuser;
  logic                           m_axis_tlast;
  logic                           cfg_we;
  logic [prt_pkg::TICK_W-1:0]     cfg_data;

  // Shadow copy of the table and the timeout register
  logic                       tbl_valid   [TBL_DEPTH];
  logic [prt_pkg::CODE_W-1:0] tbl_code    [TBL_DEPTH];
  logic [prt_pkg::CONN_W-1:0] tbl_client  [TBL_DEPTH];
  logic [prt_pkg::CONN_W-1:0] tbl_server  [TBL_DEPTH];
  logic [prt_pkg::TICK_W-1:0] tbl_created [TBL_DEPTH];
  logic [prt_pkg::TICK_W-1:0] timeout_model;

  prt_pkg::res_t              awaited_results[$];
  prt_pkg::res_t              want;
  int                         error_count;
  bit                         quiet;
  logic [prt_pkg::TICK_W-1:0] tick_now;
  logic [prt_pkg::CODE_W-1:0] code_pool [4];
  logic [prt_pkg::CONN_W-1:0] conn_pool [4];

  pending_request_table_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("pending_request_table_core_tb failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, exp_val, $time);
    error_count++;
  endtask

  // Apply one request to the shadow table and queue the results it causes
  task automatic compute_table_results(input prt_pkg::req_t r, input bit push);
    prt_pkg::res_t              batch[$];
    prt_pkg::res_t              res;
    logic [prt_pkg::TICK_W-1:0] age;
    logic [prt_pkg::CONN_W-1:0] id;
    bit                         any;
    bit                         done;
    int                         i;
    res = '0;
    res.last = 1'b1;
    done = 1'b0;
    case (r.action)
      prt_pkg::ACT_INSERT: begin
        res.status = prt_pkg::ST_FULL;
        for (i = 0; i < TBL_DEPTH; i++) begin
          if (!done && !tbl_valid[i]) begin
            tbl_valid[i] = 1'b1;
            tbl_code[i] = r.code;
            tbl_client[i] = r.client;
            tbl_server[i] = r.server;
            tbl_created[i] = r.now;
            res.status = prt_pkg::ST_OK;
            res.slot = prt_pkg::SLOT_W'(i);
            done = 1'b1;
          end
        end
        batch.push_back(res);
      end
      prt_pkg::ACT_FIND: begin
        res.status = prt_pkg::ST_NOT_FOUND;
        for (i = 0; i < TBL_DEPTH; i++) begin
          if (!done && tbl_valid[i] && tbl_code[i] == r.code) begin
            res.status = prt_pkg::ST_OK;
            res.slot = prt_pkg::SLOT_W'(i);
            done = 1'b1;
          end
        end
        batch.push_back(res);
      end
      prt_pkg::ACT_REMOVE_SLOT: begin
        res.slot = r.slot;
        res.status = tbl_valid[r.slot] ? prt_pkg::ST_OK : prt_pkg::ST_NOT_FOUND;
        tbl_valid[r.slot] = 1'b0;
        batch.push_back(res);
      end
      prt_pkg::ACT_REMOVE_CLIENT, prt_pkg::ACT_REMOVE_SERVER: begin
        any = 1'b0;
        for (i = 0; i < TBL_DEPTH; i++) begin
          id = (r.action == prt_pkg::ACT_REMOVE_CLIENT) ? tbl_client[i] : tbl_server[i];
          if (tbl_valid[i] && id == r.conn) begin
            tbl_valid[i] = 1'b0;
            any = 1'b1;
          end
        end
        res.status = any ? prt_pkg::ST_OK : prt_pkg::ST_NOT_FOUND;
        batch.push_back(res);
      end
      prt_pkg::ACT_EXPIRE: begin
        // Report in slot order, dropping each entry as it goes out
        for (i = 0; i < TBL_DEPTH; i++) begin
          age = r.now - tbl_created[i];
          if (tbl_valid[i] && age > timeout_model &&
              batch.size() < prt_pkg::MAX_RESULTS) begin
            tbl_valid[i] = 1'b0;
            res = '0;
            res.status = prt_pkg::ST_EXPIRED;
            res.slot = prt_pkg::SLOT_W'(i);
            res.code = tbl_code[i];
            res.client = tbl_client[i];
            batch.push_back(res);
          end
        end
        if (batch.size() == 0) begin
          res = '0;
          res.status = prt_pkg::ST_NONE_EXPIRED;
          batch.push_back(res);
        end
        batch[batch.size()-1].last = 1'b1;
      end
      prt_pkg::ACT_READ: begin
        res.slot = r.slot;
        if (tbl_valid[r.slot]) begin
          res.status = prt_pkg::ST_OK;
          res.code = tbl_code[r.slot];
          res.client = tbl_client[r.slot];
          res.server = tbl_server[r.slot];
          res.created = tbl_created[r.slot];
        end else begin
          res.status = prt_pkg::ST_NOT_FOUND;
        end
        batch.push_back(res);
      end
      default: ;
    endcase
    if (push) begin
      for (i = 0; i < batch.size(); i++) awaited_results.push_back(batch[i]);
    end
  endtask

  // Drive one request from a falling edge and hold it until accepted
  task automatic send_request(input prt_pkg::req_t r, input bit typed,
                              input prt_pkg::status_t st, input logic [3:0] slot);
    prt_pkg::res_t res;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    s_axis_tuser  <= r.action;
    s_axis_tdata  <= {4'b0, r.conn, r.slot, r.now, r.server, r.client, r.code};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    compute_table_results(r, !typed);
    if (typed) begin
      res = '0;
      res.status = st;
      res.slot = slot;
      res.last = 1'b1;
      awaited_results.push_back(res);
    end
    @(negedge clk);
  endtask

  // Wait until the block has drained and gone quiet
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_timeout(input logic [prt_pkg::TICK_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    timeout_model = value;
  endtask

  function automatic directed_row_t make_row(
      input prt_pkg::action_t act, input logic [31:0] code, input logic [15:0] client,
      input logic [15:0] server, input logic [31:0] now, input logic [3:0] slot,
      input logic [15:0] conn, input int unsigned reps, input bit typed,
      input prt_pkg::status_t st, input logic [3:0] exp_slot);
    directed_row_t row;
    row.req.action = act;
    row.req.code   = code;
    row.req.client = client;
    row.req.server = server;
    row.req.now    = now;
    row.req.slot   = slot;
    row.req.conn   = conn;
    row.reps  = reps;
    row.typed = typed;
    row.st    = st;
    row.slot  = exp_slot;
    return row;
  endfunction

  // Random request: pooled codes and ids so finds and removes hit
  task automatic make_random_request(output prt_pkg::req_t r);
    int unsigned                pick;
    logic [prt_pkg::TICK_W-1:0] span;
    span = (timeout_model >> 3) + 32'd2;
    tick_now = tick_now + $urandom_range(0, span);
    r.code   = ($urandom_range(0, 3) == 0) ? $urandom : code_pool[$urandom_range(0, 3)];
    r.client = ($urandom_range(0, 3) == 0) ? prt_pkg::CONN_W'($urandom)
                                            : conn_pool[$urandom_range(0, 3)];
    r.server = ($urandom_range(0, 3) == 0) ? prt_pkg::CONN_W'($urandom)
                                            : conn_pool[$urandom_range(0, 3)];
    r.conn   = ($urandom_range(0, 3) == 0) ? prt_pkg::CONN_W'($urandom)
                                            : conn_pool[$urandom_range(0, 3)];
    r.now    = ($urandom_range(0, 15) == 0) ? $urandom : tick_now;
    r.slot   = prt_pkg::SLOT_W'($urandom_range(0, TBL_DEPTH - 1));
    pick = $urandom_range(0, 99);
    if (pick < 33)      r.action = prt_pkg::ACT_INSERT;
    else if (pick < 45) r.action = prt_pkg::ACT_FIND;
    else if (pick < 55) r.action = prt_pkg::ACT_REMOVE_SLOT;
    else if (pick < 63) r.action = prt_pkg::ACT_REMOVE_CLIENT;
    else if (pick < 71) r.action = prt_pkg::ACT_REMOVE_SERVER;
    else if (pick < 84) r.action = prt_pkg::ACT_EXPIRE;
    else if (pick < 97) r.action = prt_pkg::ACT_READ;
    else                r.action = prt_pkg::action_t'(ACT_UNUSED);
  endtask

  // Result side back-pressure in random bursts
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (!quiet && stall_left == 0 && $urandom_range(0, 3) == 0)
        stall_left = $urandom_range(1, 9);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing awaited", 32'(m_axis_tuser), 32'd0);
      end else begin
        want = awaited_results.pop_front();
        if (m_axis_tuser != want.status)
          report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
        if (m_axis_tdata[3:0] != want.slot)
          report_mismatch("slot", 32'(m_axis_tdata[3:0]), 32'(want.slot));
        if (m_axis_tdata[35:4] != want.code)
          report_mismatch("code", m_axis_tdata[35:4], want.code);
        if (m_axis_tdata[51:36] != want.client)
          report_mismatch("client", 32'(m_axis_tdata[51:36]), 32'(want.client));
        if (m_axis_tdata[67:52] != want.server)
          report_mismatch("server", 32'(m_axis_tdata[67:52]), 32'(want.server));
        if (m_axis_tdata[99:68] != want.created)
          report_mismatch("created", m_axis_tdata[99:68], want.created);
        if (m_axis_tdata[103:100] != 4'b0)
          report_mismatch("pad", 32'(m_axis_tdata[103:100]), 32'd0);
        if (m_axis_tlast != want.last)
          report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
      end
    end
  end

  initial begin
    directed_row_t              rows[$];
    prt_pkg::req_t              r;
    logic [prt_pkg::TICK_W-1:0] timeout_plan [PHASE_COUNT];
    int                         count;
    int                         i;

    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    error_count = 0;
    quiet = 1'b0;
    tick_now = '0;
    timeout_model = prt_pkg::TIMEOUT_RESET;
    for (i = 0; i < TBL_DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_code[i] = '0;
      tbl_client[i] = '0;
      tbl_server[i] = '0;
      tbl_created[i] = '0;
    end

    // Empty table, extremes, boundary ages, full table and a full expire
    rows.push_back(make_row(prt_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 1, 1,
                            prt_pkg::ST_NOT_FOUND, 0));
    rows.push_back(make_row(prt_pkg::ACT_READ, 0, 0, 0, 0, 15, 0, 1, 1,
                            prt_pkg::ST_NOT_FOUND, 15));
    rows.push_back(make_row(prt_pkg::ACT_FIND, 0, 0, 0, 0, 0, 0, 1, 1,
                            prt_pkg::ST_NOT_FOUND, 0));
    rows.push_back(make_row(prt_pkg::ACT_EXPIRE, 0, 0, 0, '1, 0, 0, 1, 1,
                            prt_pkg::ST_NONE_EXPIRED, 0));
    rows.push_back(make_row(prt_pkg::ACT_REMOVE_SLOT, 0, 0, 0, 0, 15, 0, 1, 1,
                            prt_pkg::ST_NOT_FOUND, 15));
    rows.push_back(make_row(prt_pkg::ACT_REMOVE_CLIENT, 0, 0, 0, 0, 0, 0, 1, 1,
                            prt_pkg::ST_NOT_FOUND, 0));
    rows.push_back(make_row(prt_pkg::ACT_REMOVE_SERVER, 0, 0, 0, 0, 0, '1, 1, 1,
                            prt_pkg::ST_NOT_FOUND, 0));
    rows.push_back(make_row(prt_pkg::action_t'(ACT_UNUSED), '1, '1, '1, '1, '1, '1, 1, 0,
                            prt_pkg::ST_OK, 0));
    rows.push_back(make_row(prt_pkg::ACT_INSERT, '1, '1, '1, '1, 0, 0, 1, 1,
                            prt_pkg::ST_OK, 0));
    rows.push_back(make_row(prt_pkg::ACT_INSERT, 0, 0, 0, 0, 0, 0, 1, 1,
                            prt_pkg::ST_OK, 1));
    rows.push_back(make_row(prt_pkg::ACT_INSERT, 32'h4142_4344, 5, 6, 7, 0, 0, 1, 1,
                            prt_pkg::ST_OK, 2));
    rows.push_back(make_row(prt_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 1, 0,
                            prt_pkg::ST_OK, 0));
    rows.push_back(make_row(prt_pkg::ACT_FIND, '1, 0, 0, 0, 0, 0, 1, 1,
                            prt_pkg::ST_OK, 0));
    rows.push_back(make_row(prt_pkg::ACT_FIND, 0, 0, 0, 0, 0, 0, 1, 1,
                            prt_pkg::ST_OK, 1));
    // age exactly at the timeout stays, one tick past it goes
    rows.push_back(make_row(prt_pkg::ACT_EXPIRE, 0, 0, 0, 30000, 0, 0, 1, 0,
                            prt_pkg::ST_OK, 0));
    rows.push_back(make_row(prt_pkg::ACT_REMOVE_CLIENT, 0, 0, 0, 0, 0, 0, 1, 1,
                            prt_pkg::ST_OK, 0));
    rows.push_back(make_row(prt_pkg::ACT_REMOVE_SERVER, 0, 0, 0, 0, 0, 6, 1, 1,
                            prt_pkg::ST_OK, 0));
    rows.push_back(make_row(prt_pkg::ACT_REMOVE_SLOT, 0, 0, 0, 0, 2, 0, 1, 1,
                            prt_pkg::ST_NOT_FOUND, 2));
    rows.push_back(make_row(prt_pkg::ACT_INSERT, 32'h55AA_55AA, 16'hA5A5, 16'h5A5A,
                            32'h7FFF_FFFF, 0, 0, TBL_DEPTH, 0, prt_pkg::ST_OK, 0));
    rows.push_back(make_row(prt_pkg::ACT_INSERT, 1, 1, 1, 1, 0, 0, 1, 1,
                            prt_pkg::ST_FULL, 0));
    rows.push_back(make_row(prt_pkg::ACT_READ, 0, 0, 0, 0, 15, 0, 1, 0,
                            prt_pkg::ST_OK, 0));
    rows.push_back(make_row(prt_pkg::ACT_REMOVE_SLOT, 0, 0, 0, 0, 9, 0, 1, 1,
                            prt_pkg::ST_OK, 9));
    rows.push_back(make_row(prt_pkg::ACT_INSERT, 32'h55AA_55AA, 16'hA5A5, 16'h5A5A,
                            32'h7FFF_FFFF, 0, 0, 1, 1, prt_pkg::ST_OK, 9));
    rows.push_back(make_row(prt_pkg::ACT_EXPIRE, 0, 0, 0, 32'h8000_7530, 0, 0, 1, 0,
                            prt_pkg::ST_OK, 0));

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < rows.size(); i++) begin
      repeat (rows[i].reps) send_request(rows[i].req, rows[i].typed, rows[i].st,
                                         rows[i].slot);
    end

    // Random phases, each under its own timeout
    timeout_plan[0] = '0;
    timeout_plan[1] = '1;
    timeout_plan[2] = 32'd1000;
    timeout_plan[3] = $urandom;
    timeout_plan[4] = prt_pkg::TIMEOUT_RESET;
    timeout_plan[5] = 32'd50;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      settle_idle();
      write_timeout(timeout_plan[p]);
      for (i = 0; i < 4; i++) begin
        code_pool[i] = $urandom;
        conn_pool[i] = prt_pkg::CONN_W'($urandom);
      end
      tick_now = $urandom;
      quiet = (p == PHASE_COUNT - 1);
      count = 0;
      while (count < PHASE_REQUESTS) begin
        make_random_request(r);
        send_request(r, 1'b0, prt_pkg::ST_OK, 4'd0);
        if (r.action != ACT_UNUSED) count++;
      end
    end

    settle_idle();
    if (error_count == 0) begin
      $display("pending_request_table_core_tb passed");
    end else begin
      $display("pending_request_table_core_tb failed");
    end
    $finish;
  end

endmodule

// File: pending_request_table_core.f
hw/rtl/prt_pkg.sv
hw/rtl/prt_cell.sv
hw/rtl/prt_seq.sv
hw/rtl/pending_request_table_core.sv
bench/pending_request_table_core_tb.sv
